// ===== hw/rtl/gsrsd_pkg.sv =====
// ----------------------------------------------------------------------------
// gsrsd_pkg: shared types and constants of the slope detector
// Frame geometry, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package gsrsd_pkg;

    localparam int FRAME_DEPTH = 1024;
    localparam int AW          = $clog2(FRAME_DEPTH);
    localparam int CW          = AW + 1;
    localparam int MAX_EVENTS  = 64;
    localparam int EVW         = $clog2(MAX_EVENTS + 2);
    localparam int AREA_W      = 26;
    localparam int SW          = 16;
    localparam int VW          = 32;
    localparam int LW          = 10;

    localparam logic [1:0] REG_NSTD = 2'd0;
    localparam logic [1:0] REG_MAX  = 2'd1;
    localparam logic [1:0] REG_MIN  = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_CHK, S_CLS_MUL, S_CLS_CMP, S_WL, S_WL_CMP,
        S_WR, S_WR_CMP, S_LEN, S_AR, S_AR_ACC, S_EMIT, S_FIN
    } t_state;

    typedef enum logic [1:0] {A_I, A_DN, A_UP, A_J} t_addr_sel;

    typedef struct packed {
        logic      wr_en;
        logic      init;
        t_addr_sel addr_sel;
        logic      cls_reg;
        logic      i_inc;
        logic      walk_start;
        logic      wl_step;
        logic      wl_done;
        logic      wr_step;
        logic      wr_done;
        logic      area_start;
        logic      area_acc;
        logic      ev_commit;
        logic      resume_set;
        logic      resume_clr;
        logic      fin_push;
    } t_cmd;

    typedef struct packed {
        logic i_ge_to;
        logic resume;
        logic cls_hit;
        logic cls_same;
        logic wl_at_lim;
        logic wl_go;
        logic wr_at_lim;
        logic wr_go;
        logic len_ok;
        logic j_done;
        logic pend_v;
        logic ev_lt_max;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic              valid;
        logic              dir;
        logic [LW-1:0]     start_i;
        logic [LW-1:0]     end_i;
        logic [SW-1:0]     amp;
        logic [AREA_W-1:0] area;
        logic              ovf;
        logic              last;
    } t_result;

endpackage

// ===== hw/rtl/gsrsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsrsd_ctrl: scan sequencer
// Loads the frame, then steps classify, side walks, area sweep and emit.
// ----------------------------------------------------------------------------
module gsrsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  gsrsd_pkg::t_status i_sts,
    output logic              o_in_ready,
    output gsrsd_pkg::t_cmd   o_cmd
);
    import gsrsd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:    if (i_in_valid && i_in_last) n_state = S_INIT;
            S_INIT:    n_state = S_CHK;
            S_CHK:     n_state = i_sts.i_ge_to ? S_FIN : S_CLS_MUL;
            S_CLS_MUL: n_state = S_CLS_CMP;
            S_CLS_CMP: begin
                if (!i_sts.resume && i_sts.cls_hit) n_state = S_WL;
                else                                n_state = S_CHK;
            end
            S_WL:      n_state = i_sts.wl_at_lim ? S_WR : S_WL_CMP;
            S_WL_CMP:  n_state = i_sts.wl_go ? S_WL : S_WR;
            S_WR:      n_state = i_sts.wr_at_lim ? S_LEN : S_WR_CMP;
            S_WR_CMP:  n_state = i_sts.wr_go ? S_WR : S_LEN;
            S_LEN:     n_state = i_sts.len_ok ? S_AR : S_CHK;
            S_AR:      n_state = i_sts.j_done ? S_EMIT : S_AR_ACC;
            S_AR_ACC:  n_state = S_AR;
            S_EMIT: begin
                if (!(i_sts.ev_lt_max && i_sts.pend_v && !i_sts.out_free)) n_state = S_CHK;
            end
            S_FIN:     if (i_sts.out_free) n_state = S_LOAD;
            default:   n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.wr_en  = i_in_valid;
            end
            S_INIT:    o_cmd.init = 1'b1;
            S_CHK:     o_cmd.addr_sel = A_I;
            S_CLS_MUL: o_cmd.cls_reg = 1'b1;
            S_CLS_CMP: begin
                if (i_sts.resume) begin
                    o_cmd.i_inc      = 1'b1;
                    o_cmd.resume_clr = !i_sts.cls_same;
                end else if (i_sts.cls_hit) begin
                    o_cmd.walk_start = 1'b1;
                end else begin
                    o_cmd.i_inc = 1'b1;
                end
            end
            S_WL: begin
                o_cmd.addr_sel = A_DN;
                o_cmd.wl_done  = i_sts.wl_at_lim;
            end
            S_WL_CMP: begin
                o_cmd.wl_step = i_sts.wl_go;
                o_cmd.wl_done = !i_sts.wl_go;
            end
            S_WR: begin
                o_cmd.addr_sel = A_UP;
                o_cmd.wr_done  = i_sts.wr_at_lim;
            end
            S_WR_CMP: begin
                o_cmd.wr_step = i_sts.wr_go;
                o_cmd.wr_done = !i_sts.wr_go;
            end
            S_LEN: begin
                o_cmd.area_start = i_sts.len_ok;
                o_cmd.resume_set = !i_sts.len_ok;
            end
            S_AR:      o_cmd.addr_sel = A_J;
            S_AR_ACC:  o_cmd.area_acc = 1'b1;
            S_EMIT: begin
                if (!(i_sts.ev_lt_max && i_sts.pend_v && !i_sts.out_free)) begin
                    o_cmd.ev_commit  = 1'b1;
                    o_cmd.resume_set = 1'b1;
                end
            end
            S_FIN:     o_cmd.fin_push = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/gsrsd_dpath.sv =====
// ----------------------------------------------------------------------------
// gsrsd_dpath: frame stores, classify arithmetic, walk and area registers
// Holds one pending slope so the final word of a frame can carry last.
// ----------------------------------------------------------------------------
module gsrsd_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gsrsd_pkg::t_cmd             i_cmd,
    input  logic [gsrsd_pkg::SW-1:0]    i_sample,
    input  logic [gsrsd_pkg::SW-1:0]    i_mean,
    input  logic [gsrsd_pkg::VW-1:0]    i_var,
    input  logic [15:0]                 i_nstd,
    input  logic [gsrsd_pkg::LW-1:0]    i_max,
    input  logic [gsrsd_pkg::LW-1:0]    i_min,
    input  logic                        i_out_ready,
    output gsrsd_pkg::t_status          o_sts,
    output logic                        o_out_valid,
    output gsrsd_pkg::t_result          o_out
);
    import gsrsd_pkg::*;

    logic [SW-1:0] mem_s [FRAME_DEPTH];
    logic [SW-1:0] mem_m [FRAME_DEPTH];
    logic [VW-1:0] mem_v [FRAME_DEPTH];
    logic [SW-1:0] r_rd_s, r_rd_m;
    logic [VW-1:0] r_rd_v;

    logic [CW-1:0]     r_cnt, r_i, r_to;
    logic [EVW-1:0]    r_ev;
    logic [LW-2:0]     r_half;
    logic [AW-1:0]     r_pos, r_liml, r_limr, r_left, r_right, r_j;
    logic [SW-1:0]     r_cur, r_si, r_sl, r_sr, r_amp, r_base;
    logic [AREA_W-1:0] r_area;
    logic [31:0]       r_sq;
    logic [47:0]       r_rhs;
    logic              r_neg, r_nz, r_dir, r_resume;
    logic              r_pend_v, r_out_v;
    t_result           r_pend, r_out;

    logic [AW-1:0]     rd_addr;
    logic [SW:0]       dif;
    logic [SW-1:0]     mag;
    logic [LW-1:0]     max_minus_half;
    logic [CW-1:0]     ipl;
    logic [AW-1:0]     nm1;
    logic [AREA_W:0]   area_sum;
    logic              push_ev, out_free;
    t_result           new_res;
    t_result           fin_res;

    always_comb begin
        case (i_cmd.addr_sel)
            A_I:     rd_addr = r_i[AW-1:0];
            A_DN:    rd_addr = r_pos - AW'(1);
            A_UP:    rd_addr = r_pos + AW'(1);
            A_J:     rd_addr = r_j;
            default: rd_addr = r_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && r_cnt < CW'(FRAME_DEPTH)) begin
            mem_s[r_cnt[AW-1:0]] <= i_sample;
            mem_m[r_cnt[AW-1:0]] <= i_mean;
            mem_v[r_cnt[AW-1:0]] <= i_var;
        end
        r_rd_s <= mem_s[rd_addr];
        r_rd_m <= mem_m[rd_addr];
        r_rd_v <= mem_v[rd_addr];
    end

    assign dif            = {1'b0, r_rd_s} - {1'b0, r_rd_m};
    assign mag            = dif[SW] ? SW'(-dif) : dif[SW-1:0];
    assign max_minus_half = i_max - LW'(i_max[LW-1:1]);
    assign ipl            = CW'(r_i) + CW'(r_half);
    assign nm1            = AW'(r_cnt - CW'(1));
    assign area_sum       = {1'b0, r_area} + (AREA_W + 1)'(r_rd_s - r_base);
    assign out_free       = !r_out_v || i_out_ready;
    assign push_ev        = i_cmd.ev_commit && r_ev < EVW'(MAX_EVENTS) && r_pend_v;

    always_comb begin
        new_res         = '0;
        new_res.valid   = 1'b1;
        new_res.dir     = r_dir;
        new_res.start_i = LW'(r_left);
        new_res.end_i   = LW'(r_right);
        new_res.amp     = r_amp - r_base;
        new_res.area    = r_area;
    end

    // final word of the frame: pending slope or the empty-frame word
    always_comb begin
        fin_res      = r_pend_v ? r_pend : '0;
        fin_res.ovf  = r_pend_v && r_ev > EVW'(MAX_EVENTS);
        fin_res.last = 1'b1;
    end

    // classify, walk and area registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_half   <= i_max[LW-1:1];
            r_i      <= CW'(i_max[LW-1:1]);
            r_to     <= (r_cnt > CW'(max_minus_half)) ? r_cnt - CW'(max_minus_half) : '0;
            r_resume <= 1'b0;
        end
        if (i_cmd.cls_reg) begin
            r_sq  <= 32'(mag) * 32'(mag);
            r_rhs <= 48'(i_nstd) * 48'(r_rd_v);
            r_neg <= dif[SW];
            r_nz  <= dif != '0;
            r_si  <= r_rd_s;
        end
        if (i_cmd.i_inc) r_i <= r_i + CW'(1);
        if (i_cmd.resume_clr) r_resume <= 1'b0;
        if (i_cmd.walk_start) begin
            r_pos  <= r_i[AW-1:0];
            r_cur  <= r_si;
            r_dir  <= r_neg;
            r_liml <= (r_i <= CW'(r_half)) ? '0 : AW'(r_i - CW'(r_half));
            r_limr <= (ipl > CW'(nm1)) ? nm1 : AW'(ipl);
        end
        if (i_cmd.wl_step || i_cmd.wr_step) begin
            r_cur <= r_rd_s;
            r_pos <= i_cmd.wl_step ? r_pos - AW'(1) : r_pos + AW'(1);
        end
        if (i_cmd.wl_done) begin
            r_left <= r_pos;
            r_sl   <= r_cur;
            r_pos  <= r_i[AW-1:0];
            r_cur  <= r_si;
        end
        if (i_cmd.wr_done) begin
            r_right <= r_pos;
            r_sr    <= r_cur;
        end
        if (i_cmd.area_start) begin
            r_j    <= r_left;
            r_base <= (r_sr < r_sl) ? r_sr : r_sl;
            r_amp  <= r_sr;
            r_area <= '0;
        end
        if (i_cmd.area_acc) begin
            r_j <= r_j + AW'(1);
            if (r_rd_s > r_amp) r_amp <= r_rd_s;
            if (r_rd_s > r_base) begin
                r_area <= area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
            end
        end
        // resume scan from the interval end
        if (i_cmd.resume_set) begin
            r_i      <= CW'(r_right);
            r_resume <= 1'b1;
        end
        if (i_cmd.ev_commit && r_ev < EVW'(MAX_EVENTS)) r_pend <= new_res;
    end

    // control state: counts, pending flag, output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ev     <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.wr_en && r_cnt < CW'(FRAME_DEPTH)) r_cnt <= r_cnt + CW'(1);
            if (i_cmd.ev_commit) begin
                if (r_ev <= EVW'(MAX_EVENTS)) r_ev <= r_ev + EVW'(1);
                if (r_ev < EVW'(MAX_EVENTS)) r_pend_v <= 1'b1;
            end
            if (i_cmd.fin_push) begin
                r_cnt    <= '0;
                r_ev     <= '0;
                r_pend_v <= 1'b0;
            end
            if (push_ev || i_cmd.fin_push) r_out_v <= 1'b1;
            else if (i_out_ready)          r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ev) begin
            r_out <= r_pend;
        end else if (i_cmd.fin_push) begin
            r_out <= fin_res;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.i_ge_to   = r_i >= r_to;
        o_sts.resume    = r_resume;
        o_sts.cls_hit   = r_nz && ({8'b0, r_sq, 8'b0} > r_rhs);
        o_sts.cls_same  = o_sts.cls_hit && (r_neg == r_dir);
        o_sts.wl_at_lim = r_pos <= r_liml;
        o_sts.wl_go     = r_dir ? (r_cur <= r_rd_s) : (r_cur >= r_rd_s);
        o_sts.wr_at_lim = r_pos >= r_limr;
        o_sts.wr_go     = r_dir ? (r_cur >= r_rd_s) : (r_cur <= r_rd_s);
        o_sts.len_ok    = LW'(r_right - r_left) >= i_min;
        o_sts.j_done    = r_j >= r_right;
        o_sts.pend_v    = r_pend_v;
        o_sts.ev_lt_max = r_ev < EVW'(MAX_EVENTS);
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/gsr_slope_detector_unit.sv =====
// ----------------------------------------------------------------------------
// gsr_slope_detector_unit: slope finder over a frame of conductance samples
// Load: one word per cycle. Scan: check, multiply and compare states per
// classified sample, read and compare states per walk step, read and
// accumulate states per area sample; the frame store has a single read port.
// Results leave through a one-word output register, the last one from the
// FIN state after the final scan check, or later if the previous word waits.
// Reset (synchronous, active low) empties the frame and loads register defaults.
// ----------------------------------------------------------------------------
module gsr_slope_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // gsr_sample, moving_mean, moving_variance
    input  logic        i_s_tlast,   // frame_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // start_index, end_index, amplitude, area, pad
    output logic [2:0]  o_m_tuser,   // event_valid, direction, overflow
    output logic        o_m_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gsrsd_pkg::*;

    logic [15:0]   r_nstd;
    logic [LW-1:0] r_max, r_min;
    t_cmd          cmd;
    t_status       sts;
    t_result       res;
    logic          in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nstd <= 16'd1024;
            r_max  <= LW'(256);
            r_min  <= LW'(32);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_NSTD: r_nstd <= pwdata[15:0];
                REG_MAX:  r_max  <= pwdata[LW-1:0];
                REG_MIN:  r_min  <= pwdata[LW-1:0];
                default:  r_min  <= r_min;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NSTD: prdata = {16'b0, r_nstd};
            REG_MAX:  prdata = {22'b0, r_max};
            REG_MIN:  prdata = {22'b0, r_min};
            default:  prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    gsrsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_last  (i_s_tlast),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    gsrsd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (i_s_tdata[15:0]),
        .i_mean      (i_s_tdata[31:16]),
        .i_var       (i_s_tdata[63:32]),
        .i_nstd      (r_nstd),
        .i_max       (r_max),
        .i_min       (r_min),
        .i_out_ready (i_m_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .o_out       (res)
    );

    assign o_s_tready = in_ready;
    assign o_m_tdata  = {2'b0, res.area, res.amp, res.end_i, res.start_i};
    assign o_m_tuser  = {res.ovf, res.dir, res.valid};
    assign o_m_tlast  = res.last;

endmodule
